### hdl/itp_pkg.sv
// Shared types, token codes and constants for the infix-to-postfix converter.
// No dependencies; used by every module of the block except itp_ram.
package itp_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH);      // stack address bits
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);  // fill count bits
  localparam int ENTRY_W     = 10;                       // {kind, code}

  // Field widths
  localparam int KIND_W   = 4;
  localparam int CODE_W   = 6;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int PREC_W   = 3;

  // Token classes
  localparam logic [KIND_W-1:0] K_OPND  = 4'd0;
  localparam logic [KIND_W-1:0] K_FUNC  = 4'd1;
  localparam logic [KIND_W-1:0] K_COMMA = 4'd2;
  localparam logic [KIND_W-1:0] K_OPEN  = 4'd3;
  localparam logic [KIND_W-1:0] K_CLOSE = 4'd4;
  localparam logic [KIND_W-1:0] K_ADD   = 4'd5;
  localparam logic [KIND_W-1:0] K_SUB   = 4'd6;
  localparam logic [KIND_W-1:0] K_MUL   = 4'd7;
  localparam logic [KIND_W-1:0] K_DIV   = 4'd8;
  localparam logic [KIND_W-1:0] K_NEG   = 4'd9;
  localparam logic [KIND_W-1:0] K_POW   = 4'd10;
  localparam logic [KIND_W-1:0] K_END   = 4'd11;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_TOKEN = 3'd0;
  localparam logic [STATUS_W-1:0] ST_END   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COMMA = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLOSE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OPEN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVFL  = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CLOSE,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Controller -> datapath
  typedef struct packed {
    logic                load_tok;
    logic                emit;      // push a result into the hold stage
    logic                emit_top;  // result is the stack top, else the token
    logic                emit_pay;  // carry token payload
    logic [STATUS_W-1:0] status;
    logic                flush;     // item done: hand hold stage out as last
    cnt_op_t             cnt_op;
    logic                set_disc;
    logic                clr_disc;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] tok_kind;
    logic [KIND_W-1:0] top_kind;
    logic              cnt_zero;
    logic              cnt_full;
    logic              discard;
    logic              emit_ready;
    logic              flush_ready;
  } stat_t;

  // Operator precedence; zero stops a pop run
  function automatic logic [PREC_W-1:0] prec_of(input logic [KIND_W-1:0] k);
    logic [PREC_W-1:0] p;
    case (k)
      K_ADD, K_SUB: p = 3'd2;
      K_MUL, K_DIV: p = 3'd3;
      K_NEG:        p = 3'd4;
      K_POW:        p = 3'd5;
      default:      p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

### hdl/itp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/itp_ctrl.sv
// Sequencer of the converter: accepts items and drives pops, pushes and results.
// Depends on itp_pkg.
module itp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itp_pkg::stat_t st,
  output itp_pkg::cmd_t  cmd
);
  import itp_pkg::*;

  state_t            state_r, state_nxt;
  logic              pop_sep, pop_bin;
  logic [PREC_W-1:0] p_top, p_cur;

  assign p_top   = prec_of(st.top_kind);
  assign p_cur   = prec_of(st.tok_kind);
  // comma, close and end pop until an open paren
  assign pop_sep = !st.cnt_zero && (st.top_kind != K_OPEN);
  // power is right-associative
  assign pop_bin = !st.cnt_zero && (p_top != '0) &&
                   ((st.tok_kind == K_POW) ? (p_top > p_cur) : (p_top >= p_cur));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_tok = 1'b1;
          state_nxt    = S_EVAL;
        end
      end

      S_EVAL: begin
        if (st.emit_ready) begin
          state_nxt = S_FLUSH;
          if (st.discard) begin
            cmd.clr_disc = (st.tok_kind == K_END);
          end else begin
            case (st.tok_kind)
              K_FUNC, K_OPEN, K_NEG: begin
                if (st.cnt_full) begin
                  cmd.emit     = 1'b1;
                  cmd.status   = ST_OVFL;
                  cmd.cnt_op   = CNT_CLR;
                  cmd.set_disc = 1'b1;
                end else begin
                  cmd.cnt_op = CNT_INC;
                end
              end
              K_COMMA, K_CLOSE, K_END: begin
                if (pop_sep) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_top = 1'b1;
                  cmd.cnt_op   = CNT_DEC;
                  state_nxt    = S_EVAL;
                end else if (st.tok_kind == K_END) begin
                  cmd.emit   = 1'b1;
                  cmd.status = st.cnt_zero ? ST_END : ST_OPEN;
                  cmd.cnt_op = CNT_CLR;
                end else if (st.cnt_zero) begin
                  cmd.emit     = 1'b1;
                  cmd.status   = (st.tok_kind == K_COMMA) ? ST_COMMA : ST_CLOSE;
                  cmd.cnt_op   = CNT_CLR;
                  cmd.set_disc = 1'b1;
                end else if (st.tok_kind == K_CLOSE) begin
                  // drop the open paren, then look at the new top
                  cmd.cnt_op = CNT_DEC;
                  state_nxt  = S_CLOSE;
                end
              end
              K_ADD, K_SUB, K_MUL, K_DIV, K_POW: begin
                if (pop_bin) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_top = 1'b1;
                  cmd.cnt_op   = CNT_DEC;
                  state_nxt    = S_EVAL;
                end else if (st.cnt_full) begin
                  cmd.emit     = 1'b1;
                  cmd.status   = ST_OVFL;
                  cmd.cnt_op   = CNT_CLR;
                  cmd.set_disc = 1'b1;
                end else begin
                  cmd.cnt_op = CNT_INC;
                end
              end
              default: begin
                // operands and unknown classes pass through
                cmd.emit     = 1'b1;
                cmd.emit_pay = 1'b1;
                cmd.status   = ST_TOKEN;
              end
            endcase
          end
        end
      end

      S_CLOSE: begin
        if (st.emit_ready) begin
          state_nxt = S_FLUSH;
          if (!st.cnt_zero && (st.top_kind inside {K_FUNC, K_NEG})) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.cnt_op   = CNT_DEC;
          end
        end
      end

      S_FLUSH: begin
        if (st.flush_ready) begin
          cmd.flush = 1'b1;
          in_stall  = 1'b0;
          if (in_valid) begin
            cmd.load_tok = 1'b1;
            state_nxt    = S_EVAL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/itp_dpath.sv
// Datapath: token register, operator stack with fill count, hold and output stages.
// Depends on itp_pkg and itp_ram.
module itp_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [itp_pkg::KIND_W-1:0]    in_kind,
  input  logic [itp_pkg::CODE_W-1:0]    in_token_code,
  input  logic [itp_pkg::PAY_W-1:0]     in_payload,
  input  itp_pkg::cmd_t                 cmd,
  output itp_pkg::stat_t                st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itp_pkg::KIND_W-1:0]    out_kind,
  output logic [itp_pkg::CODE_W-1:0]    out_code,
  output logic [itp_pkg::PAY_W-1:0]     out_payload,
  output logic [itp_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);
  import itp_pkg::*;

  // current token
  logic [KIND_W-1:0]   tok_kind_r;
  logic [CODE_W-1:0]   tok_code_r;
  logic [PAY_W-1:0]    tok_pay_r;

  // stack control
  logic [CNT_W-1:0]    count_r, count_nxt, rd_cnt;
  logic                disc_r;
  logic [SP_W-1:0]     raddr;
  logic [ENTRY_W-1:0]  top_data;

  // hold stage (one result behind, so the last flag is known at flush)
  logic                hold_valid_r;
  logic [KIND_W-1:0]   hold_kind_r;
  logic [CODE_W-1:0]   hold_code_r;
  logic [PAY_W-1:0]    hold_pay_r;
  logic [STATUS_W-1:0] hold_status_r;

  // output stage
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [PAY_W-1:0]    out_pay_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic                out_free, move;
  logic [KIND_W-1:0]   em_kind;
  logic [CODE_W-1:0]   em_code;
  logic [PAY_W-1:0]    em_pay;
  logic [STATUS_W-1:0] em_status;

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CNT_W'(1);
      CNT_DEC: count_nxt = count_r - CNT_W'(1);
      CNT_CLR: count_nxt = '0;
      default: count_nxt = count_r;
    endcase
  end

  // read the top of the next count so it is ready the following cycle
  assign rd_cnt = count_nxt - CNT_W'(1);
  assign raddr  = rd_cnt[SP_W-1:0];

  itp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.cnt_op == CNT_INC),
    .waddr (count_r[SP_W-1:0]),
    .wdata ({tok_kind_r, tok_code_r}),
    .raddr (raddr),
    .rdata (top_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign move     = (cmd.emit || cmd.flush) && hold_valid_r;

  assign em_kind   = cmd.emit_top ? top_data[ENTRY_W-1:CODE_W] : tok_kind_r;
  assign em_code   = cmd.emit_top ? top_data[CODE_W-1:0] : tok_code_r;
  assign em_pay    = cmd.emit_pay ? tok_pay_r : '0;
  assign em_status = cmd.emit_top ? ST_TOKEN : cmd.status;

  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      tok_kind_r <= in_kind;
      tok_code_r <= in_token_code;
      tok_pay_r  <= in_payload;
    end
    if (cmd.emit) begin
      hold_kind_r   <= em_kind;
      hold_code_r   <= em_code;
      hold_pay_r    <= em_pay;
      hold_status_r <= em_status;
    end
    if (move) begin
      out_kind_r   <= hold_kind_r;
      out_code_r   <= hold_code_r;
      out_pay_r    <= hold_pay_r;
      out_status_r <= hold_status_r;
      out_last_r   <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      disc_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.set_disc) begin
        disc_r <= 1'b1;
      end else if (cmd.clr_disc) begin
        disc_r <= 1'b0;
      end
      if (cmd.emit) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.tok_kind    = tok_kind_r;
  assign st.top_kind    = top_data[ENTRY_W-1:CODE_W];
  assign st.cnt_zero    = (count_r == '0);
  assign st.cnt_full    = (count_r == CNT_W'(STACK_DEPTH));
  assign st.discard     = disc_r;
  assign st.emit_ready  = !hold_valid_r || out_free;
  assign st.flush_ready = !hold_valid_r || out_free;

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_code    = out_code_r;
  assign out_payload = out_pay_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_INC) |-> (count_r < CNT_W'(STACK_DEPTH)))
    else $error("push onto full stack");

  a_hold_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (move) |-> out_free)
    else $error("output stage overwritten while stalled");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && !cmd.emit) |=> !hold_valid_r)
    else $error("hold stage not emptied at end of item");
`endif

endmodule

### hdl/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg, itp_ctrl, itp_dpath (which holds the itp_ram stack).
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_kind, in_token_code, in_payload
//  out      output     out_valid/out_stall out_kind, out_code, out_payload,
//                                         out_status, out_last
//
// Steps: a token that pops nothing is accepted, then evaluated; the
//   end-of-item handoff overlaps the next accept. Each popped stack entry adds
//   an evaluate step, a close paren a step for the function/negation check.
//   The registered stack RAM read gives one pop per cycle unless output stalls.
// Reset: synchronous, active low; clears stack count, discard flag and valids.
//   Stack contents are not cleared; only entries below the count are used.
// Stalls: out_stall holds the output register; results then back up into the
//   one-entry hold stage and the sequencer waits. in_stall is high while busy.
module infix_to_postfix_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [itp_pkg::KIND_W-1:0]   in_kind,
  input  logic [itp_pkg::CODE_W-1:0]   in_token_code,
  input  logic [itp_pkg::PAY_W-1:0]    in_payload,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [itp_pkg::KIND_W-1:0]   out_kind,
  output logic [itp_pkg::CODE_W-1:0]   out_code,
  output logic [itp_pkg::PAY_W-1:0]    out_payload,
  output logic [itp_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last
);
  import itp_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: decides pops, pushes and results per token
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // token register, operator stack, hold and output stages
  itp_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_token_code (in_token_code),
    .in_payload    (in_payload),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_code      (out_code),
    .out_payload   (out_payload),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule
